FILE: design/gtj_pkg.sv
package gtj_pkg;

   localparam int MAX_WIDTH_DEF = 32;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam int CFG_DW = 32;
   localparam logic [0:0] REG_LINE_WIDTH = 1'b0;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic accept;      // take the character on the input
      logic append;      // copy the finished word into the line
      logic emit_start;  // prepare an emission pass
      logic emit_step;   // produce one character of the line
      logic last_line;   // the line being emitted is the final one
      logic cfg_clear;   // a width write discards everything
   } gtj_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_flush;  // the finished word does not fit the buffered line
      logic emit_done;   // the last character of the line is being produced
      logic copy_busy;   // a word is still being copied into the line store
   } gtj_stat_type;

endpackage

FILE: design/gtj_ram.sv
module gtj_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/gtj_datapath.sv
module gtj_datapath #(
   parameter int MAX_WIDTH = gtj_pkg::MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gtj_pkg::gtj_cmd_type cmd,
   output gtj_pkg::gtj_stat_type stat,
   input  logic [5:0]           width,
   input  logic [7:0]           in_char,
   output logic [7:0]           out_char,
   output logic                 end_of_line,
   output logic                 word_overflow
);
   import gtj_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int MAX_WORDS = (MAX_WIDTH + 1) / 2;
   localparam int WAW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   // Effective width.
   logic [5:0] w_eff;
   always_comb begin
      priority if (width == 6'd0) begin
         w_eff = 6'd1;
      end else if (width > 6'(MAX_WIDTH)) begin
         w_eff = 6'(MAX_WIDTH);
      end else begin
         w_eff = width;
      end
   end

   logic [5:0] cur_len_ff, cur_len_in;
   logic       ovf_ff, ovf_in;
   logic [5:0] line_len_ff, line_len_in;
   logic [5:0] words_ff, words_in;
   logic       cut_ff, cut_in;
   // Word characters live in registers: a word is copied whole into the line.
   logic [7:0] word_ff [MAX_WIDTH];
   logic [5:0] wlen_ff [MAX_WORDS];

   // Line store memory (written while a word is appended, one char a cycle).
   logic [5:0] app_idx_ff, app_idx_in;
   logic       app_busy_ff, app_busy_in;
   logic [5:0] app_off_ff, app_off_in;
   logic       wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] wr_data, rd_data;

   // Emission state.
   logic [5:0] pos_ff, pos_in;
   logic [5:0] src_ff, src_in;
   logic [5:0] k_ff, k_in;
   logic [5:0] i_ff, i_in;
   logic [5:0] g_ff, g_in;
   logic       in_gap_ff, in_gap_in;
   logic [5:0] base_ff, base_in;
   logic [5:0] extra_ff, extra_in;
   logic       last_ff, last_in;
   // Spare / gaps by restoring division, one bit per cycle during setup.
   logic [5:0] div_rem_ff, div_rem_in;
   logic [5:0] div_q_ff, div_q_in;
   logic [2:0] div_cnt_ff, div_cnt_in;

   logic [5:0] gaps, chars, spare;
   assign gaps  = (words_ff != 6'd0) ? words_ff - 6'd1 : 6'd0;
   assign chars = line_len_ff - gaps;
   assign spare = (w_eff > chars) ? w_eff - chars : 6'd0;

   logic [5:0] cur_wlen;
   assign cur_wlen = wlen_ff[k_ff[WAW-1:0]];

   // Slot of the word most recently appended, the one being copied.
   logic [5:0] new_idx;
   assign new_idx = words_ff - 6'd1;

   always_comb begin
      cur_len_in  = cur_len_ff;
      ovf_in      = ovf_ff;
      line_len_in = line_len_ff;
      words_in    = words_ff;
      cut_in      = cut_ff;
      app_idx_in  = app_idx_ff;
      app_busy_in = app_busy_ff;
      app_off_in  = app_off_ff;
      pos_in = pos_ff; src_in = src_ff; k_in = k_ff; i_in = i_ff; g_in = g_ff;
      in_gap_in = in_gap_ff; base_in = base_ff; extra_in = extra_ff;
      last_in = last_ff;
      div_rem_in = div_rem_ff; div_q_in = div_q_ff; div_cnt_in = div_cnt_ff;
      wr_en   = 1'b0;
      wr_addr = app_off_ff[AW-1:0] + app_idx_ff[AW-1:0];
      wr_data = word_ff[app_idx_ff[AW-1:0]];
      rd_addr = src_ff[AW-1:0];

      if (cmd.accept) begin
         if (cur_len_ff < w_eff) begin
            cur_len_in = cur_len_ff + 6'd1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.append) begin
         app_off_in  = (words_ff != 6'd0) ? line_len_ff - (words_ff - 6'd1) : 6'd0;
         app_idx_in  = 6'd0;
         app_busy_in = (cur_len_ff != 6'd0);
         line_len_in = line_len_ff + cur_len_ff + ((words_ff != 6'd0) ? 6'd1 : 6'd0);
         words_in    = words_ff + 6'd1;
         cut_in      = cut_ff | ovf_ff;
         cur_len_in  = 6'd0;
         ovf_in      = 1'b0;
      end
      if (app_busy_ff) begin
         wr_en      = 1'b1;
         app_idx_in = app_idx_ff + 6'd1;
         if (app_idx_ff + 6'd1 >= wlen_ff[new_idx[WAW-1:0]]) begin
            app_busy_in = 1'b0;
         end
      end
      if (cmd.emit_start) begin
         last_in    = cmd.last_line;
         pos_in     = 6'd0;
         src_in     = 6'd0;
         k_in       = 6'd0;
         i_in       = 6'd0;
         in_gap_in  = 1'b0;
         div_rem_in = 6'd0;
         div_q_in   = spare;
         div_cnt_in = 3'd6;
         rd_addr    = '0;
      end else if (div_cnt_ff != 3'd0) begin
         div_cnt_in = div_cnt_ff - 3'd1;
         if ({div_rem_ff[4:0], div_q_ff[5]} >= gaps && gaps != 6'd0) begin
            div_rem_in = {div_rem_ff[4:0], div_q_ff[5]} - gaps;
            div_q_in   = {div_q_ff[4:0], 1'b1};
         end else begin
            div_rem_in = {div_rem_ff[4:0], div_q_ff[5]};
            div_q_in   = {div_q_ff[4:0], 1'b0};
         end
         if (div_cnt_ff == 3'd1) begin
            if (gaps != 6'd0 && !last_ff) begin
               base_in  = div_q_in;
               extra_in = div_rem_in;
            end else begin
               base_in  = 6'd0;
               extra_in = 6'd0;
            end
         end
      end
      if (cmd.emit_step) begin
         pos_in = pos_ff + 6'd1;
      end
      if (cmd.emit_step && !in_gap_ff && k_ff < words_ff && i_ff < cur_wlen) begin
         src_in  = src_ff + 6'd1;
         rd_addr = src_in[AW-1:0];
         i_in    = i_ff + 6'd1;
      end else if (cmd.emit_step && in_gap_ff && g_ff != 6'd0) begin
         g_in = g_ff - 6'd1;
      end
      // Advance over finished words and gaps so the next cycle sees the
      // right character class.
      if (cmd.emit_step) begin
         if (!in_gap_ff && k_ff < words_ff && i_in >= cur_wlen) begin
            if (k_ff + 6'd1 < words_ff) begin
               in_gap_in = 1'b1;
               g_in = last_ff ? 6'd1 : base_ff + ((k_ff < extra_ff) ? 6'd1 : 6'd0);
            end else begin
               k_in = k_ff + 6'd1;
            end
         end else if (in_gap_ff && g_in == 6'd0) begin
            in_gap_in = 1'b0;
            k_in = k_ff + 6'd1;
            i_in = 6'd0;
         end
      end
      if (cmd.emit_step && stat.emit_done) begin
         line_len_in = (cmd.append) ? line_len_in : 6'd0;
         words_in    = 6'd0;
         cut_in      = 1'b0;
      end
      if (cmd.cfg_clear) begin
         cur_len_in  = 6'd0;
         ovf_in      = 1'b0;
         line_len_in = 6'd0;
         words_in    = 6'd0;
         cut_in      = 1'b0;
         app_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && cur_len_ff < w_eff) begin
         word_ff[cur_len_ff[AW-1:0]] <= in_char;
      end
      if (cmd.append) begin
         wlen_ff[words_ff[WAW-1:0]] <= cur_len_ff;
      end
      app_idx_ff <= app_idx_in; app_off_ff <= app_off_in;
      pos_ff <= pos_in; src_ff <= src_in; k_ff <= k_in; i_ff <= i_in; g_ff <= g_in;
      in_gap_ff <= in_gap_in; base_ff <= base_in; extra_ff <= extra_in;
      last_ff <= last_in; div_rem_ff <= div_rem_in; div_q_ff <= div_q_in;
      if (reset) begin
         cur_len_ff <= '0; ovf_ff <= 1'b0; line_len_ff <= '0; words_ff <= '0;
         cut_ff <= 1'b0; app_busy_ff <= 1'b0; div_cnt_ff <= '0;
      end else begin
         cur_len_ff <= cur_len_in; ovf_ff <= ovf_in; line_len_ff <= line_len_in;
         words_ff <= words_in; cut_ff <= cut_in; app_busy_ff <= app_busy_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   gtj_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign stat.need_flush = (words_ff != 6'd0) &&
                            (7'(line_len_ff) + 7'd1 + 7'(cur_len_ff) > 7'(w_eff));
   assign stat.emit_done  = (pos_ff + 6'd1 == w_eff);
   assign stat.copy_busy  = app_busy_ff;

   assign out_char      = (!in_gap_ff && k_ff < words_ff && i_ff < cur_wlen) ?
                          rd_data : SPACE_CHAR;
   assign end_of_line   = stat.emit_done;
   assign word_overflow = cut_ff;

endmodule

FILE: design/gtj_ctrl.sv
module gtj_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  word_end,
   input  logic                  final_word,
   input  logic                  cfg_write,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_last,
   output gtj_pkg::gtj_cmd_type  cmd,
   input  gtj_pkg::gtj_stat_type stat
);
   import gtj_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_APPEND = 3'd1;
   localparam logic [2:0] S_SETUP  = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;
   localparam logic [2:0] S_WAIT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;
   logic       flush_ff, flush_in;
   logic [3:0] wait_ff, wait_in;

   always_comb begin
      state_in   = state_ff;
      fin_in     = fin_ff;
      flush_in   = flush_ff;
      wait_in    = wait_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_last   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (word_end) begin
                  fin_in   = final_word;
                  state_in = S_APPEND;
               end
            end
         end
         S_APPEND: begin
            if (stat.need_flush) begin
               flush_in       = 1'b1;
               cmd.emit_start = 1'b1;
               state_in       = S_SETUP;
            end else begin
               cmd.append = 1'b1;
               wait_in    = 4'd0;
               flush_in   = 1'b0;
               state_in   = S_WAIT;
            end
            wait_in = 4'd0;
         end
         S_SETUP: begin
            wait_in = wait_ff + 4'd1;
            if (wait_ff == 4'd7) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_tvalid   = 1'b1;
            cmd.last_line = !flush_ff;
            rsp_last     = stat.emit_done && !(flush_ff && fin_ff);
            if (rsp_tready) begin
               cmd.emit_step = 1'b1;
               if (stat.emit_done) begin
                  state_in = flush_ff ? S_APPEND : S_IDLE;
                  flush_in = 1'b0;
                  if (flush_ff) begin
                     // Line was flushed; now append the pending word.
                     state_in = S_APPEND;
                  end
               end
            end
         end
         S_WAIT: begin
            // Let the word copy finish before any read of the line store.
            if (!stat.copy_busy) begin
               if (fin_ff) begin
                  cmd.emit_start = 1'b1;
                  cmd.last_line  = 1'b1;
                  fin_in         = 1'b0;
                  wait_in        = 4'd0;
                  state_in       = S_SETUP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cfg_write) begin
         cmd.cfg_clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff   <= 1'b0;
         flush_ff <= 1'b0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         flush_ff <= flush_in;
         wait_ff  <= wait_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   a_out_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == S_EMIT)) else $error("result outside emit");
   a_emit_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.append && cmd.emit_step)) else $error("append during emit");

endmodule

FILE: design/greedy_text_justifier.sv
// Greedy full text justifier.
// Input stream (req_*): one character per beat; tuser carries word_end in
// bit 0 and final_word in bit 1. Output stream (rsp_*): one character of a
// justified line per beat; tlast marks the last beat caused by one input
// beat, tuser carries end_of_line (bit 0) and word_overflow (bit 1).
// The line width register is written over the APB-style csr_ port at
// address 0; a write discards the partial word and the buffered line.
// A character that does not end a word takes only its own beat. A word end
// of L characters takes the beat itself, an append step, then the copy of
// each character into the line store and a check that the copy finished.
// Each emitted line first passes a setup phase that runs the bit-serial
// spare-space divider, then gives one character per output beat (W
// characters for a line of width W); a line flushed ahead of a word then
// returns to the append step.
// The input accepts no beat while a line is being emitted or a word copied.
// When the receiver stalls, the current output beat holds until taken.
// Reset returns the width to 16 and empties the line and word buffers.
module greedy_text_justifier #(
   parameter int MAX_WIDTH = gtj_pkg::MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_char
   input  logic [1:0]  req_tuser,   // word_end, final_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_char
   output logic        rsp_tlast,   // last_of_run
   output logic [1:0]  rsp_tuser,   // end_of_line, word_overflow
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gtj_pkg::*;

   logic [5:0]   width_ff;
   logic         cfg_write;
   gtj_cmd_type  cmd;
   gtj_stat_type stat;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_LINE_WIDTH) && (csr_paddr[1:0] == 2'b00);
   assign csr_prdata = (csr_paddr[2] == REG_LINE_WIDTH) ? {26'd0, width_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 6'd16;
      end else if (cfg_write) begin
         width_ff <= csr_pwdata[5:0];
      end
   end

   gtj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .word_end  (req_tuser[0]),
      .final_word(req_tuser[1]),
      .cfg_write (cfg_write),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_last  (rsp_tlast),
      .cmd       (cmd),
      .stat      (stat)
   );

   gtj_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .width        (width_ff),
      .in_char      (req_tdata),
      .out_char     (rsp_tdata),
      .end_of_line  (rsp_tuser[0]),
      .word_overflow(rsp_tuser[1])
   );

endmodule
